// ===== design/c2dmc_pkg.sv =====
`timescale 1ns / 1ps
package c2dmc_pkg;

  localparam int DEF_MAX_HEIGHT   = 32;
  localparam int DEF_MAX_WIDTH    = 32;
  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_MAX_FILTERS  = 8;
  localparam int DEF_MAX_KERNEL   = 5;

  localparam int DIM_W      = 9;
  localparam int CNT_W      = 7;
  localparam int KER_W      = 4;
  localparam int STR_W      = 4;
  localparam int STRIDE_MAX = 8;

  localparam int VAL_W       = 16;
  localparam int SUM_W       = 40;
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 6;

  localparam logic [IN_TUSER_W-1:0] ACT_LOAD_SAMPLE = 2'd0;
  localparam logic [IN_TUSER_W-1:0] ACT_LOAD_WEIGHT = 2'd1;
  localparam logic [IN_TUSER_W-1:0] ACT_COMPUTE     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_ROWS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_COLS   = 3'd7;

  typedef struct packed {
    logic [DIM_W-1:0] ih;
    logic [DIM_W-1:0] iw;
    logic [CNT_W-1:0] nc;
    logic [CNT_W-1:0] nf;
    logic [KER_W-1:0] kh;
    logic [KER_W-1:0] kw;
    logic [STR_W-1:0] sr;
    logic [STR_W-1:0] sc;
  } c2dmc_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } c2dmc_state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ===== design/c2dmc_cfg.sv =====
`timescale 1ns / 1ps
module c2dmc_cfg #(
  parameter int MAX_HEIGHT   = c2dmc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH    = c2dmc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = c2dmc_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_FILTERS  = c2dmc_pkg::DEF_MAX_FILTERS,
  parameter int MAX_KERNEL   = c2dmc_pkg::DEF_MAX_KERNEL
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [c2dmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [c2dmc_pkg::CFG_DATA_W-1:0] cfg_data,
  output c2dmc_pkg::c2dmc_cfg_t            cfg
);
  import c2dmc_pkg::*;

  logic [5:0] ih_r;
  logic [5:0] iw_r;
  logic [3:0] nc_r;
  logic [3:0] nf_r;
  logic [2:0] kh_r;
  logic [2:0] kw_r;
  logic [3:0] sr_r;
  logic [3:0] sc_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ih_r <= 6'd32;
      iw_r <= 6'd32;
      nc_r <= 4'd1;
      nf_r <= 4'd1;
      kh_r <= 3'd3;
      kw_r <= 3'd3;
      sr_r <= 4'd1;
      sc_r <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_HEIGHT:  ih_r <= cfg_data[5:0];
        REG_IMAGE_WIDTH:   iw_r <= cfg_data[5:0];
        REG_CHANNEL_COUNT: nc_r <= cfg_data[3:0];
        REG_FILTER_COUNT:  nf_r <= cfg_data[3:0];
        REG_KERNEL_HEIGHT: kh_r <= cfg_data[2:0];
        REG_KERNEL_WIDTH:  kw_r <= cfg_data[2:0];
        REG_STRIDE_ROWS:   sr_r <= cfg_data[3:0];
        REG_STRIDE_COLS:   sc_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // saturate each register into its usable range
  always_comb begin
    cfg.ih = clamp_dim(DIM_W'(ih_r), DIM_W'(MAX_HEIGHT));
    cfg.iw = clamp_dim(DIM_W'(iw_r), DIM_W'(MAX_WIDTH));
    cfg.nc = CNT_W'(clamp_dim(DIM_W'(nc_r), DIM_W'(MAX_CHANNELS)));
    cfg.nf = CNT_W'(clamp_dim(DIM_W'(nf_r), DIM_W'(MAX_FILTERS)));
    cfg.kh = KER_W'(clamp_dim(DIM_W'(kh_r), DIM_W'(MAX_KERNEL)));
    cfg.kw = KER_W'(clamp_dim(DIM_W'(kw_r), DIM_W'(MAX_KERNEL)));
    cfg.sr = STR_W'(clamp_dim(DIM_W'(sr_r), DIM_W'(STRIDE_MAX)));
    cfg.sc = STR_W'(clamp_dim(DIM_W'(sc_r), DIM_W'(STRIDE_MAX)));
  end

endmodule

// ===== design/c2dmc_stores.sv =====
`timescale 1ns / 1ps
module c2dmc_stores #(
  parameter int SDEPTH  = 8192,
  parameter int WDEPTH  = 1600,
  parameter int SADDR_W = 13,
  parameter int WADDR_W = 11
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                s_we,
  input  logic [SADDR_W-1:0]                  s_waddr,
  input  logic                                w_we,
  input  logic [WADDR_W-1:0]                  w_waddr,
  input  logic [c2dmc_pkg::VAL_W-1:0]         wdata,
  input  logic                                rd_en,
  input  logic [SADDR_W-1:0]                  s_raddr,
  input  logic [WADDR_W-1:0]                  w_raddr,
  output logic signed [c2dmc_pkg::VAL_W-1:0]  s_q,
  output logic signed [c2dmc_pkg::VAL_W-1:0]  w_q,
  output logic                                q_v
);
  import c2dmc_pkg::*;

  logic [VAL_W-1:0] smem [SDEPTH];
  logic [VAL_W-1:0] wmem [WDEPTH];
  logic             q_v_r;

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= wdata;
    end
    if (rd_en) begin
      s_q <= smem[s_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= wdata;
    end
    if (rd_en) begin
      w_q <= wmem[w_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= 1'b0;
    end else begin
      q_v_r <= rd_en;
    end
  end

  assign q_v = q_v_r;

endmodule

// ===== design/c2dmc_mac.sv =====
`timescale 1ns / 1ps
module c2dmc_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                acc_clr,
  input  logic                                q_v,
  input  logic signed [c2dmc_pkg::VAL_W-1:0]  s_q,
  input  logic signed [c2dmc_pkg::VAL_W-1:0]  w_q,
  output logic signed [c2dmc_pkg::SUM_W-1:0]  acc
);
  import c2dmc_pkg::*;

  logic signed [2*VAL_W-1:0] prod_r;
  logic                      pv_r;
  logic signed [SUM_W-1:0]   acc_r;

  always_ff @(posedge clk) begin
    prod_r <= s_q * w_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      pv_r <= q_v;
      if (acc_clr) begin
        acc_r <= '0;
      end else if (pv_r) begin
        acc_r <= acc_r + SUM_W'(prod_r);
      end
    end
  end

  assign acc = acc_r;

endmodule

// ===== design/c2dmc_seq.sv =====
`timescale 1ns / 1ps
module c2dmc_seq #(
  parameter int MAX_HEIGHT   = c2dmc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH    = c2dmc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = c2dmc_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_FILTERS  = c2dmc_pkg::DEF_MAX_FILTERS,
  parameter int MAX_KERNEL   = c2dmc_pkg::DEF_MAX_KERNEL,
  parameter int SADDR_W      = 13,
  parameter int WADDR_W      = 11
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  c2dmc_pkg::c2dmc_cfg_t            cfg,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [c2dmc_pkg::IN_TUSER_W-1:0] in_action,
  input  logic [4:0]                       in_row,
  input  logic [4:0]                       in_col,
  input  logic [2:0]                       in_channel,
  input  logic [2:0]                       in_filter,
  input  logic [2:0]                       in_tap_row,
  input  logic [2:0]                       in_tap_col,
  output logic                             s_we,
  output logic [SADDR_W-1:0]               s_waddr,
  output logic                             w_we,
  output logic [WADDR_W-1:0]               w_waddr,
  output logic                             rd_en,
  output logic [SADDR_W-1:0]               s_raddr,
  output logic [WADDR_W-1:0]               w_raddr,
  output logic                             acc_clr,
  input  logic                             out_free,
  output logic                             fin,
  output logic                             bad,
  output logic [4:0]                       req_row,
  output logic [4:0]                       req_col,
  output logic [2:0]                       req_flt
);
  import c2dmc_pkg::*;

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int KI_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

  c2dmc_state_t     state_r, state_nxt;
  logic [4:0]       row_r, row_nxt;
  logic [4:0]       col_r, col_nxt;
  logic [2:0]       flt_r, flt_nxt;
  logic [DIM_W-1:0] y0_r, y0_nxt;
  logic [DIM_W-1:0] x0_r, x0_nxt;
  logic [CH_W-1:0]  c_r, c_nxt;
  logic [KI_W-1:0]  a_r, a_nxt;
  logic [KI_W-1:0]  b_r, b_nxt;
  logic             dcnt_r, dcnt_nxt;
  logic             bad_r, bad_nxt;

  logic             accept;
  logic [DIM_W-1:0] y0_c;
  logic [DIM_W-1:0] x0_c;
  logic             bad_c;
  logic             b_last;
  logic             a_last;
  logic             c_last;

  assign accept = in_tvalid && in_tready;

  assign s_waddr = SADDR_W'((SADDR_W'(in_channel) * SADDR_W'(MAX_HEIGHT) + SADDR_W'(in_row))
                   * SADDR_W'(MAX_WIDTH) + SADDR_W'(in_col));
  assign w_waddr = WADDR_W'(((WADDR_W'(in_filter) * WADDR_W'(MAX_CHANNELS)
                   + WADDR_W'(in_channel)) * WADDR_W'(MAX_KERNEL) + WADDR_W'(in_tap_row))
                   * WADDR_W'(MAX_KERNEL) + WADDR_W'(in_tap_col));

  assign s_raddr = SADDR_W'((SADDR_W'(c_r) * SADDR_W'(MAX_HEIGHT) + SADDR_W'(y0_r)
                   + SADDR_W'(a_r)) * SADDR_W'(MAX_WIDTH) + SADDR_W'(x0_r) + SADDR_W'(b_r));
  assign w_raddr = WADDR_W'(((WADDR_W'(flt_r) * WADDR_W'(MAX_CHANNELS) + WADDR_W'(c_r))
                   * WADDR_W'(MAX_KERNEL) + WADDR_W'(a_r)) * WADDR_W'(MAX_KERNEL)
                   + WADDR_W'(b_r));

  // a position is valid when the whole kernel window lies inside the map and the filter is below the configured count
  assign y0_c  = DIM_W'(row_r) * DIM_W'(cfg.sr);
  assign x0_c  = DIM_W'(col_r) * DIM_W'(cfg.sc);
  assign bad_c = ((DIM_W+1)'(y0_c) + (DIM_W+1)'(cfg.kh) > (DIM_W+1)'(cfg.ih))
              || ((DIM_W+1)'(x0_c) + (DIM_W+1)'(cfg.kw) > (DIM_W+1)'(cfg.iw))
              || (CNT_W'(flt_r) >= cfg.nf);

  assign b_last = (KER_W'(b_r) == cfg.kw - KER_W'(1));
  assign a_last = (KER_W'(a_r) == cfg.kh - KER_W'(1));
  assign c_last = (CNT_W'(c_r) == cfg.nc - CNT_W'(1));

  assign req_row = row_r;
  assign req_col = col_r;
  assign req_flt = flt_r;
  assign bad     = bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    flt_r  <= flt_nxt;
    y0_r   <= y0_nxt;
    x0_r   <= x0_nxt;
    c_r    <= c_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    dcnt_r <= dcnt_nxt;
    bad_r  <= bad_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    flt_nxt   = flt_r;
    y0_nxt    = y0_r;
    x0_nxt    = x0_r;
    c_nxt     = c_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    dcnt_nxt  = dcnt_r;
    bad_nxt   = bad_r;
    in_tready = 1'b0;
    s_we      = 1'b0;
    w_we      = 1'b0;
    rd_en     = 1'b0;
    acc_clr   = 1'b0;
    fin       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (accept) begin
          unique case (in_action)
            ACT_LOAD_SAMPLE: begin
              s_we = (32'(in_row) < MAX_HEIGHT) && (32'(in_col) < MAX_WIDTH)
                  && (32'(in_channel) < MAX_CHANNELS);
            end
            ACT_LOAD_WEIGHT: begin
              w_we = (32'(in_filter) < MAX_FILTERS) && (32'(in_channel) < MAX_CHANNELS)
                  && (32'(in_tap_row) < MAX_KERNEL) && (32'(in_tap_col) < MAX_KERNEL);
            end
            ACT_COMPUTE: begin
              row_nxt   = in_row;
              col_nxt   = in_col;
              flt_nxt   = in_filter;
              state_nxt = ST_CHECK;
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        acc_clr   = 1'b1;
        y0_nxt    = y0_c;
        x0_nxt    = x0_c;
        c_nxt     = '0;
        a_nxt     = '0;
        b_nxt     = '0;
        bad_nxt   = bad_c;
        state_nxt = bad_c ? ST_FIN : ST_RUN;
      end
      ST_RUN: begin
        rd_en = 1'b1;
        if (!b_last) begin
          b_nxt = b_r + KI_W'(1);
        end else begin
          b_nxt = '0;
          if (!a_last) begin
            a_nxt = a_r + KI_W'(1);
          end else begin
            a_nxt = '0;
            if (!c_last) begin
              c_nxt = c_r + CH_W'(1);
            end else begin
              dcnt_nxt  = 1'b0;
              state_nxt = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        dcnt_nxt = 1'b1;
        if (dcnt_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          fin       = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== design/conv2d_multichannel_nchw_top.sv =====
`timescale 1ns / 1ps
// Strided multi-channel 2-D convolution without padding, NCHW store order. Load transfers
// write one Q8.8 sample or weight, and the block stays ready for further transfers; a
// compute transfer returns the exact Q24.16 sum for one output position and filter, or a
// flagged zero when the position lies outside the valid area or the filter is past the
// configured count. A compute runs a check state, then one shared multiply-accumulate that
// reads one sample and one weight per cycle from the two stores for each channel and tap,
// then a pipeline drain, then a hand-over of the result that waits while the output
// register is full; a flagged compute goes from the check straight to the hand-over. The block
// holds in_tready low while a compute is in progress. Store entries read before they are
// written return undefined data. Configure only while idle.
module conv2d_multichannel_nchw_top #(
  parameter int MAX_HEIGHT   = c2dmc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH    = c2dmc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = c2dmc_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_FILTERS  = c2dmc_pkg::DEF_MAX_FILTERS,
  parameter int MAX_KERNEL   = c2dmc_pkg::DEF_MAX_KERNEL
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // row, col, channel, filter, tap_row, tap_col, value, zero pad
  input  logic [c2dmc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic [c2dmc_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // conv_sum, out_row, out_col, out_filter, zero pad
  output logic [c2dmc_pkg::OUT_TDATA_W-1:0] out_tdata,
  // bad_position
  output logic                              out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [c2dmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [c2dmc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import c2dmc_pkg::*;

  localparam int SDEPTH  = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int WDEPTH  = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int SADDR_W = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

  c2dmc_cfg_t               cfg;
  logic                     s_we;
  logic [SADDR_W-1:0]       s_waddr;
  logic                     w_we;
  logic [WADDR_W-1:0]       w_waddr;
  logic                     rd_en;
  logic [SADDR_W-1:0]       s_raddr;
  logic [WADDR_W-1:0]       w_raddr;
  logic signed [VAL_W-1:0]  s_q;
  logic signed [VAL_W-1:0]  w_q;
  logic                     q_v;
  logic                     acc_clr;
  logic signed [SUM_W-1:0]  acc;
  logic                     out_free;
  logic                     fin;
  logic                     bad;
  logic [4:0]               req_row;
  logic [4:0]               req_col;
  logic [2:0]               req_flt;

  logic                     out_v_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;
  logic                     out_bad_r;

  c2dmc_cfg #(
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_FILTERS (MAX_FILTERS),
    .MAX_KERNEL  (MAX_KERNEL)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  c2dmc_seq #(
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_FILTERS (MAX_FILTERS),
    .MAX_KERNEL  (MAX_KERNEL),
    .SADDR_W     (SADDR_W),
    .WADDR_W     (WADDR_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (in_tuser),
    .in_row    (in_tdata[4:0]),
    .in_col    (in_tdata[9:5]),
    .in_channel(in_tdata[12:10]),
    .in_filter (in_tdata[15:13]),
    .in_tap_row(in_tdata[18:16]),
    .in_tap_col(in_tdata[21:19]),
    .s_we      (s_we),
    .s_waddr   (s_waddr),
    .w_we      (w_we),
    .w_waddr   (w_waddr),
    .rd_en     (rd_en),
    .s_raddr   (s_raddr),
    .w_raddr   (w_raddr),
    .acc_clr   (acc_clr),
    .out_free  (out_free),
    .fin       (fin),
    .bad       (bad),
    .req_row   (req_row),
    .req_col   (req_col),
    .req_flt   (req_flt)
  );

  c2dmc_stores #(
    .SDEPTH (SDEPTH),
    .WDEPTH (WDEPTH),
    .SADDR_W(SADDR_W),
    .WADDR_W(WADDR_W)
  ) u_stores (
    .clk    (clk),
    .rst_n  (rst_n),
    .s_we   (s_we),
    .s_waddr(s_waddr),
    .w_we   (w_we),
    .w_waddr(w_waddr),
    .wdata  (in_tdata[37:22]),
    .rd_en  (rd_en),
    .s_raddr(s_raddr),
    .w_raddr(w_raddr),
    .s_q    (s_q),
    .w_q    (w_q),
    .q_v    (q_v)
  );

  c2dmc_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc_clr(acc_clr),
    .q_v    (q_v),
    .s_q    (s_q),
    .w_q    (w_q),
    .acc    (acc)
  );

  assign out_free = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fin) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_data_r <= {3'b000, req_flt, req_col, req_row, acc};
      out_bad_r  <= bad;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_bad_r;

endmodule
